>>> hdl/hpg_pkg.sv
package hpg_pkg;

    // Lane geometry of the packed arrangement word
    localparam int MAX_ELEMENTS = 8;
    localparam int ELEMENT_BITS = 8;
    localparam int WORD_BITS    = 64;

    // Register field widths
    localparam int COUNT_BITS = 4;
    // Active lane count, 1..MAX_ELEMENTS
    localparam int NUM_BITS   = $clog2(MAX_ELEMENTS + 1);
    // Position counter i runs 0..i, and also serves as a lane index
    localparam int CNT_BITS   = $clog2(MAX_ELEMENTS);

    localparam int COUNT_RESET = 8;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ELEMENT_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_ELEMENTS = 2'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // compute the next arrangement and load the output register
        logic restart;  // restart flag of the item being worked on
    } hpg_cmd_t;

endpackage

>>> hdl/heap_permutation_generator_unit.sv
// Heap's algorithm permutation generator, one arrangement per item.
// After an accept the controller enters its step state, and m_valid rises when that step loads
// the output register. The controller takes no new item until the step has loaded its result;
// a stalled result holds the step until the output register empties.
// Reset (aresetn low, synchronous): element_count 8, initial_elements 0, counters cleared,
// sequence inactive so the first item reloads; no clearing pass.
module heap_permutation_generator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_restart,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hpg_pkg::WORD_BITS-1:0]       m_arrangement,
    output logic                                m_is_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hpg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [hpg_pkg::WORD_BITS-1:0]       cfg_data
);

    hpg_pkg::hpg_cmd_t cmd;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    hpg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    hpg_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_arrangement (m_arrangement),
        .m_is_last     (m_is_last)
    );

endmodule

>>> hdl/hpg_ctrl.sv
module hpg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_restart,
    output logic              m_valid,
    input  logic              m_ready,
    output hpg_pkg::hpg_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;
    logic   restart_reg, restart_next;
    logic   load;

    // Step only when the output register is free or being emptied
    assign load = (state_reg == ST_CALC) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        restart_next = restart_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    state_next   = ST_CALC;
                    s_ready_next = 1'b0;
                    restart_next = s_restart;
                end
            end
            ST_CALC: begin
                if (load) begin
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
            end
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            restart_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
            restart_reg <= restart_next;
        end
    end

    assign s_ready     = s_ready_reg;
    assign m_valid     = m_valid_reg;
    assign cmd.load    = load;
    assign cmd.restart = restart_reg;

endmodule

>>> hdl/hpg_datapath.sv
module hpg_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hpg_pkg::hpg_cmd_t                   cmd,
    input  logic                                cfg_write,
    input  logic [hpg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [hpg_pkg::WORD_BITS-1:0]       cfg_data,
    output logic [hpg_pkg::WORD_BITS-1:0]       m_arrangement,
    output logic                                m_is_last
);

    localparam int MAXE = hpg_pkg::MAX_ELEMENTS;
    localparam int EB   = hpg_pkg::ELEMENT_BITS;
    localparam int WB   = hpg_pkg::WORD_BITS;
    localparam int CB   = hpg_pkg::CNT_BITS;
    localparam int NB   = hpg_pkg::NUM_BITS;
    localparam int KB   = hpg_pkg::COUNT_BITS;

    logic [KB-1:0] element_count_reg;
    logic [WB-1:0] initial_reg;
    logic [WB-1:0] order_reg, order_next;
    logic [CB-1:0] cnt_reg [MAXE];
    logic [CB-1:0] cnt_next [MAXE];
    logic          active_reg;
    logic [WB-1:0] arrangement_reg;
    logic          is_last_reg;

    logic [NB-1:0] n;
    logic          found;
    logic [CB-1:0] idx;
    logic [CB-1:0] swap_a;
    logic          reload;
    logic          last;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= KB'(hpg_pkg::COUNT_RESET);
            initial_reg       <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                hpg_pkg::REG_ELEMENT_COUNT:    element_count_reg <= cfg_data[KB-1:0];
                hpg_pkg::REG_INITIAL_ELEMENTS: initial_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the lane count to 1..MAX_ELEMENTS
    always_comb begin
        if (element_count_reg == '0) begin
            n = NB'(1);
        end else if (element_count_reg > KB'(MAXE)) begin
            n = NB'(MAXE);
        end else begin
            n = element_count_reg[NB-1:0];
        end
    end

    // Lowest position whose counter can still advance
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = 1; i < MAXE; i++) begin
            if (!found && (NB'(i) < n) && (cnt_reg[i] < CB'(i))) begin
                found = 1'b1;
                idx   = CB'(i);
            end
        end
    end

    // Odd positions swap with their counter's lane, even ones with lane zero
    assign swap_a = idx[0] ? cnt_reg[idx] : '0;
    assign reload = cmd.restart || !active_reg || !found;

    // One Heap step, or a reload, and the end check on the new counters
    always_comb begin
        order_next = order_reg;
        cnt_next   = cnt_reg;
        if (reload) begin
            order_next = initial_reg;
            for (int i = 0; i < MAXE; i++) begin
                cnt_next[i] = '0;
            end
        end else begin
            for (int k = 0; k < MAXE; k++) begin
                if (CB'(k) == idx) begin
                    order_next[k*EB +: EB] = order_reg[swap_a*EB +: EB];
                end else if (CB'(k) == swap_a) begin
                    order_next[k*EB +: EB] = order_reg[idx*EB +: EB];
                end
            end
            for (int i = 1; i < MAXE; i++) begin
                if (CB'(i) < idx) begin
                    cnt_next[i] = '0;
                end else if (CB'(i) == idx) begin
                    cnt_next[i] = cnt_reg[i] + 1'b1;
                end
            end
        end
        last = 1'b1;
        for (int i = 1; i < MAXE; i++) begin
            if ((NB'(i) < n) && (cnt_next[i] < CB'(i))) begin
                last = 1'b0;
            end
        end
    end

    // Sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg  <= '0;
            active_reg <= 1'b0;
            for (int i = 0; i < MAXE; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (cmd.load) begin
            order_reg  <= order_next;
            active_reg <= !last;
            cnt_reg    <= cnt_next;
        end
    end

    // Output register, payload only
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            arrangement_reg <= order_next;
            is_last_reg     <= last;
        end
    end

    assign m_arrangement = arrangement_reg;
    assign m_is_last     = is_last_reg;

endmodule

>>> hdl/hpg_checker.sv
module hpg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [hpg_pkg::WORD_BITS-1:0]  m_arrangement,
    input logic                           m_is_last
);

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_arrangement) && $stable(m_is_last)))
    else $error("stalled result changed");

    // One item in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
    else $error("item accepted while another is in work");

    // A result never appears in the cycle right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
    else $error("result appeared too early");

    // Finishing an item frees the input side at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
    else $error("input not ready after result load");

endmodule

bind heap_permutation_generator_unit hpg_checker u_hpg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_arrangement (m_arrangement),
    .m_is_last     (m_is_last)
);
